FILE: hdl/spq_pkg.sv
package spq_pkg;

   // Queue depth and field widths.
   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int PRIO_W   = 16;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   // Request kinds.
   localparam logic [KIND_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] REQ_PEEK   = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // State of the response register.
   typedef enum logic {
      OUT_EMPTY,
      OUT_FULL
   } out_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                insert_en;
      logic                delete_en;
      logic                load_rsp;
      logic                head_out;
      logic [STATUS_W-1:0] rsp_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic             empty;
      logic             full;
      logic [CNT_W-1:0] count;
   } stat_type;

endpackage

FILE: hdl/spq_ifs.sv
// Request channel: one queue operation per request.
interface spq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [spq_pkg::KIND_W-1:0]           req_type;
   logic signed [spq_pkg::VALUE_W-1:0]   value;
   logic signed [spq_pkg::PRIO_W-1:0]    prio;

   modport source (output valid, output req_type, output value, output prio, input ready);
   modport sink   (input valid, input req_type, input value, input prio, output ready);
endinterface

// Response channel: one response per request.
interface spq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [spq_pkg::STATUS_W-1:0]         status;
   logic signed [spq_pkg::VALUE_W-1:0]   out_value;
   logic signed [spq_pkg::PRIO_W-1:0]    out_prio;
   logic [spq_pkg::FILL_W-1:0]           fill;

   modport source (output valid, output status, output out_value, output out_prio,
                   output fill, input ready);
   modport sink   (input valid, input status, input out_value, input out_prio,
                   input fill, output ready);
endinterface

FILE: hdl/stable_priority_queue.sv
// Bounded priority queue of (value, priority) entries held in descending
// priority order, earlier entries first among equal priorities. A request
// inserts, deletes the head, or peeks at the head; each request yields one
// response in the cycle after it is taken, and a new request is taken every
// cycle as long as the response side keeps up. That rate comes from the slot
// array: every slot compares its priority with the incoming one and shifts in
// the same cycle, so a whole insert or delete finishes together. The
// response register separates the two channels, so a request is accepted in
// the same cycle the previous response is taken. No clearing pass is needed
// after reset; only the entry count is cleared.
module stable_priority_queue (
   input  logic   clock,
   input  logic   reset,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp
);
   import spq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Controller: handshake and request decode.
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_kind  (req.req_type),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: slot array, entry count and response register.
   spq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .in_value   (req.value),
      .in_prio    (req.prio),
      .stat       (stat),
      .rsp_status (rsp.status),
      .rsp_value  (rsp.out_value),
      .rsp_prio   (rsp.out_prio),
      .rsp_fill   (rsp.fill)
   );

   // An accepted request always shows a response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> rsp.valid)
      else $error("no response after an accepted request");

   // An insert grows the count by one.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.insert_en |=> stat.count == $past(stat.count) + CNT_W'(1))
      else $error("insert did not grow the entry count");

   // A delete shrinks the count by one.
   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      cmd.delete_en |=> stat.count == $past(stat.count) - CNT_W'(1))
      else $error("delete did not shrink the entry count");

   // The count never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // An empty response reports zero fill.
   a_empty_fill: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == STATUS_EMPTY |-> rsp.fill == '0)
      else $error("empty response with nonzero fill");

endmodule

FILE: hdl/spq_ctrl.sv
module spq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [spq_pkg::KIND_W-1:0]   req_kind,
   output logic                         req_ready,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   input  spq_pkg::stat_type            stat,
   output spq_pkg::cmd_type             cmd
);
   import spq_pkg::*;

   out_state_type state_ff, state_in;
   logic          accept;

   // State register for the response slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OUT_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   // A new request is taken whenever the response slot is free or drains now.
   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      unique case (state_ff)
         OUT_EMPTY: begin
            req_ready = 1'b1;
         end
         OUT_FULL: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      accept = req_valid && req_ready;
      if (accept) begin
         state_in = OUT_FULL;
      end else if (state_ff == OUT_FULL && rsp_ready) begin
         state_in = OUT_EMPTY;
      end
   end

   // Decode the request into datapath commands.
   always_comb begin
      cmd            = '0;
      cmd.load_rsp   = accept;
      cmd.rsp_status = STATUS_OK;
      unique case (req_kind)
         REQ_INSERT: begin
            if (stat.full) begin
               cmd.rsp_status = STATUS_FULL;
            end else begin
               cmd.insert_en = accept;
            end
         end
         REQ_DELETE: begin
            if (stat.empty) begin
               cmd.rsp_status = STATUS_EMPTY;
            end else begin
               cmd.delete_en = accept;
               cmd.head_out  = 1'b1;
            end
         end
         REQ_PEEK: begin
            if (stat.empty) begin
               cmd.rsp_status = STATUS_EMPTY;
            end else begin
               cmd.head_out = 1'b1;
            end
         end
         default: begin
            cmd.rsp_status = STATUS_OK;
         end
      endcase
   end

endmodule

FILE: hdl/spq_dp.sv
module spq_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  spq_pkg::cmd_type                    cmd,
   input  logic signed [spq_pkg::VALUE_W-1:0]  in_value,
   input  logic signed [spq_pkg::PRIO_W-1:0]   in_prio,
   output spq_pkg::stat_type                   stat,
   output logic [spq_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [spq_pkg::VALUE_W-1:0]  rsp_value,
   output logic signed [spq_pkg::PRIO_W-1:0]   rsp_prio,
   output logic [spq_pkg::FILL_W-1:0]          rsp_fill
);
   import spq_pkg::*;

   logic signed [VALUE_W-1:0] values_ff [CAPACITY];
   logic signed [PRIO_W-1:0]  prios_ff  [CAPACITY];
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CAPACITY-1:0]       lower;

   logic [STATUS_W-1:0]       status_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [PRIO_W-1:0]  prio_ff;
   logic [FILL_W-1:0]         fill_ff;

   // Each slot flags whether the new entry goes at or before it: the slot is
   // unused, or holds a strictly lower priority. Equal priorities stay ahead.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lower[i] = (CNT_W'(i) >= count_ff) || (prios_ff[i] < in_prio);
      end
   end

   // Entry count.
   always_comb begin
      count_in = count_ff;
      if (cmd.insert_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.delete_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Slot array: insert shifts the lower part down one slot, delete shifts all up.
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (cmd.insert_en && lower[i]) begin
            if (i == 0 || !lower[(i == 0) ? 0 : i - 1]) begin
               values_ff[i] <= in_value;
               prios_ff[i]  <= in_prio;
            end else begin
               values_ff[i] <= values_ff[(i == 0) ? 0 : i - 1];
               prios_ff[i]  <= prios_ff[(i == 0) ? 0 : i - 1];
            end
         end else if (cmd.delete_en && i < CAPACITY - 1) begin
            values_ff[i] <= values_ff[(i < CAPACITY - 1) ? i + 1 : i];
            prios_ff[i]  <= prios_ff[(i < CAPACITY - 1) ? i + 1 : i];
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff <= cmd.rsp_status;
         value_ff  <= cmd.head_out ? values_ff[0] : '0;
         prio_ff   <= cmd.head_out ? prios_ff[0] : '0;
         fill_ff   <= FILL_W'(count_in);
      end
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(CAPACITY));
   assign stat.count = count_ff;
   assign rsp_status = status_ff;
   assign rsp_value  = value_ff;
   assign rsp_prio   = prio_ff;
   assign rsp_fill   = fill_ff;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import spq_pkg::*;

   // Request code with no operation behind it; the queue answers it and changes nothing.
   localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;

   // Cycles with no request or response taken before the run is declared hung.
   localparam int STALL_LIMIT = 4000;

   // One response as the queue should produce it.
   typedef struct {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0]  prio;
      logic [FILL_W-1:0]         fill;
   } queue_result_type;

   logic clock = 1'b0;
   logic reset;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   stable_priority_queue dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // Shadow copy of the queue contents, head in slot zero.
   logic signed [VALUE_W-1:0] held_value [CAPACITY];
   logic signed [PRIO_W-1:0]  held_prio  [CAPACITY];
   int                        held_count = 0;

   queue_result_type pending_results [$];
   int               mismatch_count = 0;
   int               send_idle_pct  = 0;
   int               rsp_idle_pct   = 0;
   int               stall_cycles   = 0;

   always #5 clock = ~clock;

   // Applies one request to the shadow queue and returns the response it must produce.
   function automatic queue_result_type apply_queue_request(
      input logic [KIND_W-1:0]       kind,
      input logic signed [VALUE_W-1:0] val,
      input logic signed [PRIO_W-1:0]  pri
   );
      queue_result_type res;
      int               pos;
      res.status = STATUS_OK;
      res.value  = '0;
      res.prio   = '0;
      case (kind)
         REQ_INSERT: begin
            if (held_count >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               // A new entry goes behind every entry of equal or higher priority.
               pos = 0;
               while (pos < held_count && held_prio[pos] >= pri) pos++;
               for (int i = held_count; i > pos; i--) begin
                  held_value[i] = held_value[i-1];
                  held_prio[i]  = held_prio[i-1];
               end
               held_value[pos] = val;
               held_prio[pos]  = pri;
               held_count++;
            end
         end
         REQ_DELETE, REQ_PEEK: begin
            if (held_count == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.value = held_value[0];
               res.prio  = held_prio[0];
               if (kind == REQ_DELETE) begin
                  for (int i = 1; i < held_count; i++) begin
                     held_value[i-1] = held_value[i];
                     held_prio[i-1]  = held_prio[i];
                  end
                  held_count--;
               end
            end
         end
         default: begin
         end
      endcase
      res.fill = FILL_W'(held_count);
      return res;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // Track every accepted request and check every accepted response against the oldest one.
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            pending_results.push_back(
               apply_queue_request(req_ch.req_type, req_ch.value, req_ch.prio));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               report_error("response arrived with no request outstanding");
            end else begin
               want = pending_results.pop_front();
               if (rsp_ch.status !== want.status)
                  report_error($sformatf("status got %0d expected %0d",
                                         rsp_ch.status, want.status));
               if (rsp_ch.out_value !== want.value)
                  report_error($sformatf("out_value got %0d expected %0d",
                                         rsp_ch.out_value, want.value));
               if (rsp_ch.out_prio !== want.prio)
                  report_error($sformatf("out_prio got %0d expected %0d",
                                         rsp_ch.out_prio, want.prio));
               if (rsp_ch.fill !== want.fill)
                  report_error($sformatf("fill got %0d expected %0d",
                                         rsp_ch.fill, want.fill));
            end
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("stable_priority_queue verification failed");
            $finish;
         end
      end
   end

   // The response side stalls at random at the current rate.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Offers one request, with random idle cycles ahead of it, and waits until it is taken.
   task automatic send_request(
      input logic [KIND_W-1:0]         kind,
      input logic signed [VALUE_W-1:0] val,
      input logic signed [PRIO_W-1:0]  pri
   );
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.req_type = kind;
      req_ch.value    = val;
      req_ch.prio     = pri;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Holds off new requests until every outstanding response has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Priorities lean toward a narrow band so that ties are common.
   function automatic logic signed [PRIO_W-1:0] pick_prio();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 16'sh7FFF;
      if (pick == 1) return 16'sh8000;
      if (pick < 6) return PRIO_W'(int'($urandom_range(4)) - 2);
      return PRIO_W'($urandom);
   endfunction

   // Sends one random request; returns zero when it picked the unused code.
   task automatic send_random_request(input int insert_pct, output bit counted);
      int                  pick;
      logic [KIND_W-1:0]   kind;
      pick    = $urandom_range(99);
      counted = 1'b1;
      if (pick < 3) begin
         kind    = REQ_UNUSED;
         counted = 1'b0;
      end else if (pick < 18) begin
         kind = REQ_PEEK;
      end else if ($urandom_range(99) < insert_pct) begin
         kind = REQ_INSERT;
      end else begin
         kind = REQ_DELETE;
      end
      send_request(kind, pick_value(), pick_prio());
   endtask

   // Empty queue, unused code, extreme fields, ties, and a full queue.
   task automatic test_directed();
      send_request(REQ_DELETE, '0, '0);
      send_request(REQ_PEEK, '0, '0);
      send_request(REQ_UNUSED, 32'sh7FFF_FFFF, 16'sh7FFF);
      send_request(REQ_INSERT, 32'sh7FFF_FFFF, 16'sh7FFF);
      send_request(REQ_INSERT, 32'sh8000_0000, 16'sh8000);
      send_request(REQ_INSERT, 32'sh0000_0000, 16'sh0000);
      send_request(REQ_INSERT, 32'shFFFF_FFFF, 16'shFFFF);
      send_request(REQ_INSERT, 32'sh0000_0005, 16'sh0003);
      send_request(REQ_INSERT, 32'sh0000_0006, 16'sh0003);
      send_request(REQ_INSERT, 32'sh0000_0001, 16'sh7FFF);
      send_request(REQ_INSERT, 32'sh0000_0002, 16'sh8000);
      send_request(REQ_INSERT, 32'sh5555_5555, 16'sh5555);
      send_request(REQ_INSERT, 32'shAAAA_AAAA, 16'shAAAA);
      send_request(REQ_INSERT, 32'sh0000_0007, 16'sh0003);
      for (int i = 1; i <= 5; i++) begin
         send_request(REQ_INSERT, VALUE_W'(i * 32'h0101_0101), 16'sh0003);
      end
      // The queue is now full: this insert must be dropped.
      send_request(REQ_INSERT, 32'sh1234_5678, 16'sh7FFF);
      send_request(REQ_PEEK, '0, '0);
      send_request(REQ_UNUSED, 32'sh8000_0000, 16'sh8000);
      send_request(REQ_DELETE, '0, '0);
      send_request(REQ_DELETE, '0, '0);
   endtask

   // Random traffic that swings between filling and draining the queue.
   task automatic test_random_traffic(input int item_total);
      int sent;
      int run_left;
      int insert_pct;
      bit counted;
      sent       = 0;
      run_left   = 0;
      insert_pct = 70;
      while (sent < item_total) begin
         if (run_left == 0) begin
            insert_pct = (insert_pct == 70) ? 30 : 70;
            run_left   = $urandom_range(40, 10);
         end
         send_random_request(insert_pct, counted);
         if (counted) begin
            sent++;
            run_left--;
         end
      end
   endtask

   // The sender stops until every response is back, then resumes.
   task automatic test_drain_pause();
      bit counted;
      for (int i = 0; i < 12; i++) send_random_request(60, counted);
      wait_for_drain();
      for (int i = 0; i < 12; i++) send_random_request(40, counted);
   endtask

   initial begin
      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_INSERT;
      req_ch.value    = '0;
      req_ch.prio     = '0;
      reset           = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 19;
      rsp_idle_pct  = 46;
      test_directed();
      test_random_traffic(160);
      test_drain_pause();

      send_idle_pct = 46;
      rsp_idle_pct  = 19;
      test_random_traffic(170);

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random_traffic(170);

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0)
         report_error($sformatf("%0d responses never arrived", pending_results.size()));

      if (mismatch_count == 0) begin
         $display("stable_priority_queue verification clean");
      end else begin
         $display("stable_priority_queue verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/spq_pkg.sv
hdl/spq_ifs.sv
hdl/spq_ctrl.sv
hdl/spq_dp.sv
hdl/stable_priority_queue.sv
tb/sv/tb.sv
